// ----- src/gscms_pkg.sv -----
// Package for the geometric sampled count-min sketch.
// Holds the sizing constants, operation codes, item types and the column helper.
// Depends on nothing; the top-level module imports it.
package gscms_pkg;

    localparam int SKETCH_ROWS        = 4;
    localparam int SAMPLE_TABLE_DEPTH = 4096;
    localparam int COLUMN_INDEX_BITS  = 16;

    localparam int ROW_BITS          = (SKETCH_ROWS > 1) ? $clog2(SKETCH_ROWS) : 1;
    localparam int ROW_POS_BITS      = ROW_BITS + 1;
    localparam int TABLE_ADDR_BITS   = $clog2(SAMPLE_TABLE_DEPTH);
    localparam int SKETCH_ADDR_BITS  = ROW_BITS + COLUMN_INDEX_BITS;
    localparam int SKETCH_DEPTH      = SKETCH_ROWS * (1 << COLUMN_INDEX_BITS);
    localparam int COUNTER_WIDTH     = 64;
    localparam int SAMPLE_WIDTH      = 32;

    localparam logic [1:0] OP_UPDATE        = 2'd0;
    localparam logic [1:0] OP_TABLE_WRITE   = 2'd1;
    localparam logic [1:0] OP_COUNTER_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] flow_hash;
        logic        packet_parsed;
        logic [11:0] table_index;
        logic [31:0] table_value;
        logic [1:0]  read_row;
        logic [15:0] read_column;
    } request_t;

    typedef struct packed {
        logic [2:0]  rows_updated;
        logic        zero_draw_error;
        logic [63:0] counter_value;
    } result_t;

    // Each row takes its own 16-bit slice of the hash; rows past bit 63 use column 0.
    function automatic logic [COLUMN_INDEX_BITS-1:0] sk_column(
        input logic [63:0]         hash,
        input logic [ROW_BITS-1:0] row
    );
        logic [63:0] shifted;
        shifted = hash >> {row, 4'b0000};
        return shifted[COLUMN_INDEX_BITS-1:0];
    endfunction

endpackage

// ----- src/gscms_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the sketch counters and the sampling table; depends on nothing.
module gscms_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/geometric_sampled_count_min_sketch.sv -----
// Count-min sketch with geometric row sampling, top level; uses gscms_pkg and gscms_ram.
// A table write, a skipped or unparsed packet and an unused code give their result from idle;
// a counter read passes through the read state first; a sampled packet takes k walk steps
// (k from 1 to SKETCH_ROWS), one step a cycle.
// One item is in work at a time; the next can be started in the cycle its result shows.
// After reset the counter memory is cleared one entry a cycle (all 262144 entries), busy high.
module geometric_sampled_count_min_sketch (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gscms_pkg::request_t request,
    output logic               done,
    output gscms_pkg::result_t  result
);
    import gscms_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [TABLE_ADDR_BITS-1:0]  pointer_reg, pointer_next;
    logic [SAMPLE_WIDTH-1:0]     skip_reg, skip_next;
    logic [ROW_POS_BITS-1:0]     row_reg, row_next;
    logic [ROW_BITS-1:0]         step_reg, step_next;
    logic [2:0]                  updated_reg, updated_next;
    logic [63:0]                 hash_reg, hash_next;
    logic [SKETCH_ADDR_BITS-1:0] addr_reg, addr_next;
    logic                        fwd_reg, fwd_next;
    logic [COUNTER_WIDTH-1:0]    fwd_data_reg, fwd_data_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [SKETCH_ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                        done_reg, done_next;
    result_t                     result_reg, result_next;

    logic                        cnt_we;
    logic [SKETCH_ADDR_BITS-1:0] cnt_waddr, cnt_raddr;
    logic [COUNTER_WIDTH-1:0]    cnt_wdata, cnt_rdata;
    logic                        tbl_we;
    logic [TABLE_ADDR_BITS-1:0]  tbl_raddr;
    logic [SAMPLE_WIDTH-1:0]     tbl_rdata;

    logic [COUNTER_WIDTH-1:0]    cnt_cur, cnt_inc;
    logic [SAMPLE_WIDTH:0]       row_sum;
    logic                        row_end, row_active, last_step;
    logic [ROW_POS_BITS-1:0]     walk_row;
    logic [SKETCH_ADDR_BITS-1:0] walk_addr, start_addr, read_addr;
    logic [ROW_POS_BITS-1:0]     start_row;
    logic [2:0]                  updated_total;

    gscms_ram #(
        .WIDTH (COUNTER_WIDTH),
        .DEPTH (SKETCH_DEPTH)
    ) u_counter_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    gscms_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (SAMPLE_TABLE_DEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (TABLE_ADDR_BITS'(request.table_index)),
        .wdata (request.table_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A step that hits the entry written in the cycle before takes the written value.
    assign cnt_cur    = fwd_reg ? fwd_data_reg : cnt_rdata;
    assign cnt_inc    = cnt_cur + COUNTER_WIDTH'(1);
    assign row_sum    = {1'b0, tbl_rdata} + (SAMPLE_WIDTH + 1)'(row_reg);
    assign row_end    = (row_sum >= (SAMPLE_WIDTH + 1)'(SKETCH_ROWS));
    assign row_active = (row_reg < ROW_POS_BITS'(SKETCH_ROWS));
    assign last_step  = (step_reg == ROW_BITS'(SKETCH_ROWS - 1));
    assign walk_row   = row_sum[ROW_POS_BITS-1:0];
    assign walk_addr  = {walk_row[ROW_BITS-1:0], sk_column(hash_reg, walk_row[ROW_BITS-1:0])};
    assign start_row  = skip_reg[ROW_POS_BITS-1:0];
    assign start_addr = {start_row[ROW_BITS-1:0],
                         sk_column(request.flow_hash, start_row[ROW_BITS-1:0])};
    assign read_addr  = {ROW_BITS'(request.read_row),
                         COLUMN_INDEX_BITS'(request.read_column)};
    assign updated_total = row_active ? updated_reg + 3'd1 : updated_reg;

    always_comb
    begin
        state_next    = state_reg;
        pointer_next  = pointer_reg;
        skip_next     = skip_reg;
        row_next      = row_reg;
        step_next     = step_reg;
        updated_next  = updated_reg;
        hash_next     = hash_reg;
        addr_next     = addr_reg;
        fwd_next      = 1'b0;
        fwd_data_next = cnt_inc;
        rd_ok_next    = rd_ok_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = clr_addr_reg;
        cnt_wdata     = '0;
        cnt_raddr     = addr_reg;
        tbl_we        = 1'b0;
        tbl_raddr     = pointer_reg + TABLE_ADDR_BITS'(1);

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we        = 1'b1;
                clr_addr_next = clr_addr_reg + SKETCH_ADDR_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next = '0;
                    case (request.operation)
                        OP_UPDATE:
                        begin
                            if (skip_reg > SAMPLE_WIDTH'(SKETCH_ROWS))
                            begin
                                skip_next = skip_reg - SAMPLE_WIDTH'(SKETCH_ROWS);
                                done_next = 1'b1;
                            end
                            else if (!request.packet_parsed)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cnt_raddr    = start_addr;
                                addr_next    = start_addr;
                                pointer_next = pointer_reg + TABLE_ADDR_BITS'(1);
                                row_next     = start_row;
                                step_next    = '0;
                                updated_next = '0;
                                hash_next    = request.flow_hash;
                                state_next   = ST_WALK;
                            end
                        end
                        OP_TABLE_WRITE:
                        begin
                            tbl_we    = 1'b1;
                            done_next = 1'b1;
                        end
                        OP_COUNTER_READ:
                        begin
                            cnt_raddr  = read_addr;
                            rd_ok_next = (32'(request.read_row) < SKETCH_ROWS);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (row_active)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = addr_reg;
                    cnt_wdata = cnt_inc;
                end
                updated_next = updated_total;
                if (row_end || last_step)
                begin
                    done_next                   = 1'b1;
                    result_next                 = '0;
                    result_next.rows_updated    = updated_total;
                    result_next.zero_draw_error = (tbl_rdata == '0);
                    if (tbl_rdata != '0)
                    begin
                        skip_next = tbl_rdata - SAMPLE_WIDTH'(1);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_raddr    = walk_addr;
                    addr_next    = walk_addr;
                    pointer_next = pointer_reg + TABLE_ADDR_BITS'(1);
                    row_next     = walk_row;
                    step_next    = step_reg + ROW_BITS'(1);
                    fwd_next     = row_active && (walk_addr == addr_reg);
                end
            end
            ST_READ:
            begin
                done_next                 = 1'b1;
                result_next               = '0;
                result_next.counter_value = rd_ok_reg ? cnt_rdata : '0;
                state_next                = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pointer_reg  <= '0;
            skip_reg     <= '0;
            row_reg      <= '0;
            step_reg     <= '0;
            updated_reg  <= '0;
            fwd_reg      <= 1'b0;
            rd_ok_reg    <= 1'b0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pointer_reg  <= pointer_next;
            skip_reg     <= skip_next;
            row_reg      <= row_next;
            step_reg     <= step_next;
            updated_reg  <= updated_next;
            fwd_reg      <= fwd_next;
            rd_ok_reg    <= rd_ok_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        addr_reg     <= addr_next;
        fwd_data_reg <= fwd_data_next;
        result_reg   <= result_next;
    end

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result shown during the clearing pass");

    a_counter_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (state_reg == ST_WALK || state_reg == ST_CLEAR))
        else $error("counter memory written outside the walk or clearing pass");

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.rows_updated) <= SKETCH_ROWS))
        else $error("more counter increments reported than there are rows");

    a_error_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_draw_error) |-> (result.counter_value == '0))
        else $error("zero draw flagged on a counter read result");

    a_read_takes_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation == OP_COUNTER_READ) |=> (busy && !done))
        else $error("counter read did not wait for the memory");

endmodule
